>>> rtl/sphere_distance_gradient_defines.svh
// ----------------------------------------------------------------------------
// Sphere distance gradient: assertion macros
// Clocked implication macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SPHERE_DISTANCE_GRADIENT_DEFINES_SVH
`define SPHERE_DISTANCE_GRADIENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sphere_distance_gradient: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SDG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sphere_distance_gradient: next-cycle check failed");

`endif

>>> rtl/sdg_pkg.sv
// ----------------------------------------------------------------------------
// Sphere distance gradient package
// Widths, register indexes and the beat types passed between the stages.
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = COORD_W - 1;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int REMD_W    = ROOT_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int GRAD_W    = FRAC_BITS + 2;
  localparam int DIST_W    = ROOT_W + 1;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int LANES     = 3;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(64'd1 << FRAC_BITS);
  localparam logic [QUO_W-1:0]  QUO_ONE      = QUO_W'(64'd1 << FRAC_BITS);
  localparam logic [DIST_W-1:0] DIST_HI      = DIST_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [DIST_W-1:0] DIST_LO      = ~DIST_HI;
  localparam logic [COORD_W-1:0] COORD_HI    = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_LO    = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS
  } reg_idx_e;

  // pipeline advance and the valid bit of the entering beat
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  // per-lane magnitude and sign that ride along the root stages
  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } lane_side_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
    lane_side_t        side;
  } root_beat_t;

  typedef struct packed {
    logic                        valid;
    logic [ROOT_W-1:0]           len;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][QUO_W-1:0] quo;
  } grad_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0]           sdist;
    logic [LANES-1:0][GRAD_W-1:0] grad;
    logic                         at_center;
    logic                         saturated;
  } result_t;

endpackage

>>> rtl/sdg_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring radix-4 digit recurrence, floor result.
// ----------------------------------------------------------------------------
module sdg_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sdg_pkg::pipe_ctl_t       ctl_i,
  input  logic [sdg_pkg::SUM_W-1:0] rad_i,
  input  sdg_pkg::lane_side_t      side_i,
  output sdg_pkg::root_beat_t      beat_o
);
  import sdg_pkg::*;

  logic              v_q    [ROOT_W];
  logic [SUM_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  lane_side_t        side_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_in;
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    lane_side_t        side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (i == 0) begin : g_first
      assign v_in    = ctl_i.valid;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
    assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rad_q[i]  <= rad_in << 2;
        rem_q[i]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[i] <= {root_in[ROOT_W-2:0], take};
        side_q[i] <= side_in;
      end
    end
  end

  assign beat_o.valid = v_q[ROOT_W-1];
  assign beat_o.root  = root_q[ROOT_W-1];
  assign beat_o.side  = side_q[ROOT_W-1];

endmodule

>>> rtl/sdg_grad_div.sv
// ----------------------------------------------------------------------------
// Pipelined gradient divider
// Three lanes of restoring division, floor(mag * 2^FRAC_BITS / len),
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module sdg_grad_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdg_pkg::pipe_ctl_t  ctl_i,
  input  sdg_pkg::root_beat_t beat_i,
  output sdg_pkg::grad_beat_t beat_o
);
  import sdg_pkg::*;

  localparam int DIV_ST = QUO_W;

  logic                         v_q   [DIV_ST];
  logic [ROOT_W-1:0]            len_q [DIV_ST];
  logic [LANES-1:0]             neg_q [DIV_ST];
  logic [LANES-1:0][REMD_W-1:0] rem_q [DIV_ST];
  logic [LANES-1:0][QUO_W-1:0]  quo_q [DIV_ST];

  for (genvar i = 0; i < DIV_ST; i++) begin : g_stage
    logic                         v_in;
    logic [ROOT_W-1:0]            len_in;
    logic [LANES-1:0]             neg_in;
    logic [LANES-1:0][REMD_W-1:0] rem_pre;
    logic [LANES-1:0][QUO_W-1:0]  quo_in;
    logic [LANES-1:0][REMD_W-1:0] rem_d;
    logic [LANES-1:0][QUO_W-1:0]  quo_d;

    if (i == 0) begin : g_first
      // integer quotient bit first, no shift
      assign v_in   = ctl_i.valid;
      assign len_in = beat_i.root;
      assign neg_in = beat_i.side.neg;
      assign quo_in = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_pre[l] = REMD_W'(beat_i.side.mag[l]);
      end
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign len_in = len_q[i-1];
      assign neg_in = neg_q[i-1];
      assign quo_in = quo_q[i-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_pre[l] = {rem_q[i-1][l][REMD_W-2:0], 1'b0};
      end
    end

    // compare and subtract per lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_pre[l] >= {1'b0, len_in}) begin
          rem_d[l] = rem_pre[l] - {1'b0, len_in};
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_pre[l];
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        len_q[i] <= len_in;
        neg_q[i] <= neg_in;
        rem_q[i] <= rem_d;
        quo_q[i] <= quo_d;
      end
    end
  end

  assign beat_o.valid = v_q[DIV_ST-1];
  assign beat_o.len   = len_q[DIV_ST-1];
  assign beat_o.neg   = neg_q[DIV_ST-1];
  assign beat_o.quo   = quo_q[DIV_ST-1];

endmodule

>>> rtl/sphere_distance_gradient.sv
// ----------------------------------------------------------------------------
// Sphere signed distance and unit gradient
// Distance |p - c| - r, saturated, and gradient (p - c) / |p - c| in Q1.16.
//
//   channel | dir | handshake                 | beat
//   --------+-----+---------------------------+------------------------------
//   in      | in  | in_valid_i / in_stall_o   | point_x/y/z
//   out     | out | out_valid_o / out_stall_i | distance, grad_x/y/z, flags
//   cfg     | in  | APB psel/penable/pwrite   | center_x/y/z, radius
//
// One point per clock while the skid register is empty. The path has 4 front
// stages (difference, magnitude, square, sum), 33 square-root stages, 17
// divider stages and the output register. Reset clears all valid bits and
// loads the register defaults. A stall at the output parks one beat in a skid
// register; the pipeline then freezes as a whole until the skid drains.
// ----------------------------------------------------------------------------
module sphere_distance_gradient (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sdg_pkg::COORD_W-1:0]   point_x_i,
  input  logic [sdg_pkg::COORD_W-1:0]   point_y_i,
  input  logic [sdg_pkg::COORD_W-1:0]   point_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sdg_pkg::COORD_W-1:0]   signed_distance_o,
  output logic [sdg_pkg::GRAD_W-1:0]    grad_x_o,
  output logic [sdg_pkg::GRAD_W-1:0]    grad_y_o,
  output logic [sdg_pkg::GRAD_W-1:0]    grad_z_o,
  output logic                          at_center_o,
  output logic                          saturated_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdg_pkg::ADDR_W-1:0]    paddr,
  input  logic [sdg_pkg::DATA_W-1:0]    pwdata,
  output logic [sdg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import sdg_pkg::*;

  logic [COORD_W-1:0] center_x_q, center_y_q, center_z_q;
  logic [RAD_W-1:0]   radius_q;
  reg_idx_e           reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= RADIUS_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CENTER_X: center_x_q <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: center_y_q <= pwdata[COORD_W-1:0];
        REG_CENTER_Z: center_z_q <= pwdata[COORD_W-1:0];
        REG_RADIUS:   radius_q   <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = DATA_W'(center_x_q);
      REG_CENTER_Y: prdata = DATA_W'(center_y_q);
      REG_CENTER_Z: prdata = DATA_W'(center_z_q);
      REG_RADIUS:   prdata = DATA_W'(radius_q);
      default:      prdata = '0;
    endcase
  end

  // global advance: the pipe freezes while the skid holds a beat
  logic      skid_v_q;
  logic      en;
  pipe_ctl_t ctl;

  assign en         = ~skid_v_q;
  assign in_stall_o = skid_v_q;
  assign ctl.en     = en;

  // stage 1: differences
  logic [LANES-1:0][COORD_W-1:0] pt, cen;
  logic                          v1_q;
  logic [LANES-1:0][DIFF_W-1:0]  diff1_q;

  assign pt  = {point_z_i, point_y_i, point_x_i};
  assign cen = {center_z_q, center_y_q, center_x_q};

  // stage 2: magnitudes, stage 3: squares, stage 4: sum
  logic                        v2_q, v3_q, v4_q;
  lane_side_t                  side2_q, side3_q, side4_q;
  logic [LANES-1:0][SQ_W-1:0]  sq3_q;
  logic [SUM_W-1:0]            sum4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        diff1_q[l] <= {pt[l][COORD_W-1], pt[l]} - {cen[l][COORD_W-1], cen[l]};
        side2_q.neg[l] <= diff1_q[l][DIFF_W-1];
        side2_q.mag[l] <= diff1_q[l][DIFF_W-1] ? MAG_W'(-diff1_q[l])
                                                : MAG_W'(diff1_q[l]);
        sq3_q[l] <= SQ_W'(side2_q.mag[l]) * SQ_W'(side2_q.mag[l]);
      end
      side3_q <= side2_q;
      sum4_q  <= SUM_W'(sq3_q[0]) + SUM_W'(sq3_q[1]) + SUM_W'(sq3_q[2]);
      side4_q <= side3_q;
    end
  end

  // square root, then gradient division
  root_beat_t root_beat;
  grad_beat_t grad_beat;

  assign ctl.valid = v4_q;

  sdg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rad_i  (sum4_q),
    .side_i (side4_q),
    .beat_o (root_beat)
  );

  pipe_ctl_t div_ctl;
  assign div_ctl.en    = en;
  assign div_ctl.valid = root_beat.valid;

  sdg_grad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .beat_i (root_beat),
    .beat_o (grad_beat)
  );

  // result formatting: distance saturation, gradient clamp and sign
  result_t            res;
  logic [DIST_W-1:0]  dist_raw;
  logic               sat_hi, sat_lo;
  logic [QUO_W-1:0]   qc;

  always_comb begin
    dist_raw = {1'b0, grad_beat.len} - {{(DIST_W-RAD_W){1'b0}}, radius_q};
    sat_hi   = $signed(dist_raw) > $signed(DIST_HI);
    sat_lo   = $signed(dist_raw) < $signed(DIST_LO);
    if (sat_hi) begin
      res.sdist = COORD_HI;
    end else if (sat_lo) begin
      res.sdist = COORD_LO;
    end else begin
      res.sdist = dist_raw[COORD_W-1:0];
    end
    res.saturated = sat_hi | sat_lo;
    res.at_center = (grad_beat.len == '0);
    qc = '0;
    for (int l = 0; l < LANES; l++) begin
      qc = (grad_beat.quo[l] > QUO_ONE) ? QUO_ONE : grad_beat.quo[l];
      if (res.at_center) begin
        res.grad[l] = '0;
      end else if (grad_beat.neg[l]) begin
        res.grad[l] = -{1'b0, qc};
      end else begin
        res.grad[l] = {1'b0, qc};
      end
    end
  end

  // output register with one-beat skid
  logic    out_v_q;
  result_t out_q, skid_q;
  logic    take_out, push;

  assign take_out = ~out_v_q | ~out_stall_i;
  assign push     = en & grad_beat.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take_out) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_v_q;
  assign signed_distance_o = out_q.sdist;
  assign grad_x_o          = out_q.grad[0];
  assign grad_y_o          = out_q.grad[1];
  assign grad_z_o          = out_q.grad[2];
  assign at_center_o       = out_q.at_center;
  assign saturated_o       = out_q.saturated;

endmodule

>>> rtl/sdg_checker.sv
// ----------------------------------------------------------------------------
// Sphere distance gradient port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "sphere_distance_gradient_defines.svh"

module sdg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] signed_distance_o,
  input logic [17:0] grad_x_o,
  input logic [17:0] grad_y_o,
  input logic [17:0] grad_z_o,
  input logic        at_center_o,
  input logic        saturated_o
);

  // a held result stays valid
  `SDG_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // input is only held off while a finished beat waits at the output
  `SDG_ASSERT_IMP(a_stall_has_out, in_stall_o, out_valid_o)

  // a point at the center has a zero gradient
  `SDG_ASSERT_IMP(a_center_zero, out_valid_o && at_center_o,
                  grad_x_o == 18'd0 && grad_y_o == 18'd0 && grad_z_o == 18'd0)

  // only the upper limit of the distance is reachable
  `SDG_ASSERT_IMP(a_sat_top, out_valid_o && saturated_o,
                  signed_distance_o == 32'h7fff_ffff)

endmodule

bind sphere_distance_gradient sdg_checker u_sdg_checker (.*);

>>> tb/tb_sphere_distance_gradient.sv
// ----------------------------------------------------------------------------
// Sphere distance gradient testbench
// Drives query points against several sphere settings written over APB and
// checks every distance, gradient and flag beat against a predictor kept in
// the bench. Sender bursts, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sphere_distance_gradient;
  import sdg_pkg::*;

  localparam int LATENCY = 55;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic [COORD_W-1:0] sdist;
    logic [GRAD_W-1:0]  gx;
    logic [GRAD_W-1:0]  gy;
    logic [GRAD_W-1:0]  gz;
    logic               at_center;
    logic               saturated;
  } sdf_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [COORD_W-1:0]  point_x_i = '0;
  logic [COORD_W-1:0]  point_y_i = '0;
  logic [COORD_W-1:0]  point_z_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [COORD_W-1:0]  signed_distance_o;
  logic [GRAD_W-1:0]   grad_x_o;
  logic [GRAD_W-1:0]   grad_y_o;
  logic [GRAD_W-1:0]   grad_z_o;
  logic                at_center_o;
  logic                saturated_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // bench copy of the sphere registers
  logic [COORD_W-1:0]  sph_cx;
  logic [COORD_W-1:0]  sph_cy;
  logic [COORD_W-1:0]  sph_cz;
  logic [RAD_W-1:0]    sph_rad;

  sdf_beat_t           pending_q[$];
  int                  errors = 0;
  int                  beats_in = 0;
  int                  beats_out = 0;
  int                  settings_run = 0;
  int                  burst_left = 0;
  int                  max_gap = 4;
  int                  stall_pct = 0;
  bit                  hold_req = 1'b0;
  int                  hold_cnt = 0;
  int                  center_hits = 0;
  int                  sat_hits = 0;

  sphere_distance_gradient dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted beat for one point under the current registers
  function automatic sdf_beat_t predict_sdf(input logic [COORD_W-1:0] px,
                                            input logic [COORD_W-1:0] py,
                                            input logic [COORD_W-1:0] pz);
    logic [COORD_W-1:0] pt[3];
    logic [COORD_W-1:0] cn[3];
    logic signed [33:0] d[3];
    logic [32:0]        mag[3];
    logic [67:0]        sq;
    logic [32:0]        root;
    logic [32:0]        cand;
    longint             dist_raw;
    logic [63:0]        q;
    logic [GRAD_W-1:0]  g[3];
    sdf_beat_t          r;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    cn[0] = sph_cx; cn[1] = sph_cy; cn[2] = sph_cz;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({pt[i][COORD_W-1], pt[i]}) - $signed({cn[i][COORD_W-1], cn[i]});
      mag[i] = d[i][33] ? 33'(-d[i]) : 33'(d[i]);
      sq = sq + {35'b0, mag[i]} * {35'b0, mag[i]};
    end
    // truncated integer square root
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = root | (33'd1 << b);
      if ({35'b0, cand} * {35'b0, cand} <= sq) root = cand;
    end
    dist_raw = longint'(root) - longint'(sph_rad);
    r.saturated = 1'b0;
    if (dist_raw > 64'sd2147483647) begin
      dist_raw = 64'sd2147483647;
      r.saturated = 1'b1;
    end
    r.sdist = dist_raw[COORD_W-1:0];
    r.at_center = (sq == '0);
    for (int i = 0; i < 3; i++) begin
      g[i] = '0;
      if (!r.at_center) begin
        q = ({31'b0, mag[i]} << FRAC_BITS) / {31'b0, root};
        if (q > 64'd65536) q = 64'd65536;
        if (d[i][33]) q = -q;
        g[i] = q[GRAD_W-1:0];
      end
    end
    r.gx = g[0]; r.gy = g[1]; r.gz = g[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch beat %0d %s: got %h want %h", beats_out, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    sdf_beat_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(signed_distance_o), 64'd0);
      end else begin
        w = pending_q.pop_front();
        if (signed_distance_o !== w.sdist)
          report_mismatch("distance", 64'(signed_distance_o), 64'(w.sdist));
        if (grad_x_o !== w.gx) report_mismatch("grad_x", 64'(grad_x_o), 64'(w.gx));
        if (grad_y_o !== w.gy) report_mismatch("grad_y", 64'(grad_y_o), 64'(w.gy));
        if (grad_z_o !== w.gz) report_mismatch("grad_z", 64'(grad_z_o), 64'(w.gz));
        if (at_center_o !== w.at_center)
          report_mismatch("at_center", 64'(at_center_o), 64'(w.at_center));
        if (saturated_o !== w.saturated)
          report_mismatch("saturated", 64'(saturated_o), 64'(w.saturated));
      end
      beats_out++;
    end
  end

  // receiver stall pattern, with a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic [COORD_W-1:0] pz);
    int gap;
    sdf_beat_t w;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(max_gap);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    w = predict_sdf(px, py, pz);
    if (w.at_center) center_hits++;
    if (w.saturated) sat_hits++;
    pending_q.push_back(w);
    beats_in++;
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: sph_cx = val;
      REG_CENTER_Y: sph_cy = val;
      REG_CENTER_Z: sph_cz = val;
      REG_RADIUS:   sph_rad = val[RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] rad);
    wait_idle();
    apb_write(REG_CENTER_X, cx);
    apb_write(REG_CENTER_Y, cy);
    apb_write(REG_CENTER_Z, cz);
    apb_write(REG_RADIUS, rad);
    settings_run++;
  endtask

  // point near the center in a random scale, or anywhere, or exactly on it
  task automatic send_random_point();
    logic [31:0] p[3];
    logic [31:0] c[3];
    int sel;
    c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
    sel = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (sel < 5) p[i] = c[i];
      else if (sel < 35) p[i] = $urandom();
      else p[i] = c[i] + ($urandom() >>> $urandom_range(31));
      if (sel >= 35 && $urandom_range(1)) p[i] = c[i] - ($urandom() >> $urandom_range(31));
    end
    send_point(p[0], p[1], p[2]);
  endtask

  task automatic test_directed();
    // reset defaults: unit sphere at the origin
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'hFFFF_0000, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0, 32'h1);
    send_point(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    // zero radius, center at the top corner: largest differences saturate
    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // largest radius, bottom corner center
    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h8000_0001, 32'h8000_0000, 32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_random();
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_sphere(32'h0, 32'h0, 32'h0, 32'h0001_0000);
        1: set_sphere($urandom(), $urandom(), $urandom(), $urandom());
        2: set_sphere($urandom() >>> 8, $urandom() >>> 8, $urandom() >>> 8,
                      $urandom() >> 12);
        3: set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        4: set_sphere($urandom(), 32'hFFFF_FFFF, $urandom(), 32'h0);
        default: set_sphere($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      stall_pct = (s % 3 == 0) ? 0 : 10 * s;
      max_gap = (s == 3) ? 0 : 6;
      repeat (170) send_random_point();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_sphere($urandom(), $urandom(), $urandom(), $urandom() >> 4);
    stall_pct = 20;
    max_gap = 0;
    hold_req = 1'b1;
    repeat (200) send_random_point();
    max_gap = 4;
    wait_idle();
  endtask

  initial begin
    sph_cx = '0;
    sph_cy = '0;
    sph_cz = '0;
    sph_rad = RADIUS_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    $display("%0d points, %0d result beats over %0d sphere settings", beats_in, beats_out,
             settings_run);
    $display("%0d points on the center, %0d saturated distances", center_hits, sat_hits);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d beats outstanding", pending_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sdg_pkg.sv
rtl/sdg_isqrt.sv
rtl/sdg_grad_div.sv
rtl/sphere_distance_gradient.sv
rtl/sdg_checker.sv
tb/tb_sphere_distance_gradient.sv
